/* design/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define SWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/swm_pkg.sv */
`default_nettype none
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SMP_W      = 32;
  localparam int MED_W      = SMP_W + 1;
  localparam int GRP_SIZE   = 8;
  localparam int GRP_CNT    = WINDOW_MAX / GRP_SIZE;
  localparam int SUB_W      = $clog2(GRP_SIZE);

  // One cell's view as seen by its neighbors.
  typedef struct packed {
    logic signed [SMP_W-1:0] val;
    logic [IDX_W-1:0]        age;
    logic                    gt;   // val above the incoming sample
  } swm_tap_t;

  // Zero maps to 1, anything past the max saturates.
  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] wr);
    logic [CNT_W-1:0] res;
    res = wr;
    if (wr == '0) begin
      res = CNT_W'(1);
    end else if (wr > CNT_W'(WINDOW_MAX)) begin
      res = CNT_W'(WINDOW_MAX);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* design/swm_cell.sv */
`default_nettype none
// One slot of the sorted window: value plus its age in beats.
module swm_cell (
  input  wire                           clk,
  input  wire                           load,
  input  wire signed [swm_pkg::SMP_W-1:0] sample,
  input  wire [swm_pkg::IDX_W-1:0]      oldest_age,
  input  wire                           remove,
  input  wire                           occupied,
  input  wire                           kept,      // slot valid after removal
  input  wire                           rb_in,     // removal at a lower slot
  output logic                          rb_out,
  input  swm_pkg::swm_tap_t             up_tap,    // raw view of upper neighbor
  output swm_pkg::swm_tap_t             own_tap,
  input  swm_pkg::swm_tap_t             lo_ctap,   // compacted view of lower neighbor
  output swm_pkg::swm_tap_t             ctap
);
  import swm_pkg::*;

  logic signed [SMP_W-1:0] val;
  logic [IDX_W-1:0]        age;
  logic                    rm;
  swm_tap_t                csel;
  logic signed [SMP_W-1:0] val_next;
  logic [IDX_W-1:0]        age_next;

  always_comb begin
    own_tap.val = val;
    own_tap.age = age;
    own_tap.gt  = (val > sample);
  end

  assign rm     = remove && occupied && (age == oldest_age);
  assign rb_out = rb_in | rm;

  // Close the gap left by the removed entry.
  always_comb begin
    csel    = rb_out ? up_tap : own_tap;
    ctap    = csel;
    ctap.gt = kept & csel.gt;
  end

  // Open a gap for the new sample.
  always_comb begin
    if (lo_ctap.gt) begin
      val_next = lo_ctap.val;
      age_next = IDX_W'(lo_ctap.age + 1'b1);
    end else if (ctap.gt || !kept) begin
      val_next = sample;
      age_next = '0;
    end else begin
      val_next = csel.val;
      age_next = IDX_W'(csel.age + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule
`default_nettype wire

/* design/sliding_window_median.sv */
// A result beat passes from the cell row through result stage 1 and result stage 2 before it is offered.
// Throughput: one sample per cycle unless the input stalls; the whole cell row updates together.
// Input stalls only while both result stages are full, the output is stalled
// and the cell row still owes a result.
// Reset (rst, sync): window empty, window size 1, no result pending.
// A config write sets the window size and empties the window.
`default_nettype none
module sliding_window_median (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_write,
  input  wire [swm_pkg::CNT_W-1:0]        cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire signed [swm_pkg::SMP_W-1:0] sample,
  input  wire                             restart,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [swm_pkg::MED_W-1:0] median_doubled
);
  import swm_pkg::*;

  // Control registers
  logic [CNT_W-1:0] win_size;    // effective window size, 1..WINDOW_MAX
  logic [CNT_W-1:0] fill;        // samples currently held
  logic             pend;        // cell row holds a window that owes a result
  logic             s1_valid;

  // Fill bookkeeping for the incoming beat
  logic             accept;
  logic [CNT_W-1:0] fill_base;   // fill after an optional restart
  logic             remove;      // window full: oldest entry leaves
  logic [CNT_W-1:0] kept_cnt;    // entries left after the removal
  logic [CNT_W-1:0] fill_next;
  logic             emit;
  logic [IDX_W-1:0] oldest_age;

  assign accept     = in_valid && !in_stall;
  assign fill_base  = restart ? '0 : fill;
  assign remove     = (fill_base >= win_size);
  assign kept_cnt   = fill_base - CNT_W'(remove);
  assign fill_next  = kept_cnt + CNT_W'(1);
  assign emit       = (fill_next == win_size);
  assign oldest_age = IDX_W'(win_size - CNT_W'(1));

  // Cell row: cell 0 holds the smallest sample. The removal flag ripples
  // upward; each cell picks its next entry from itself or a neighbor.
  swm_tap_t own_tap [WINDOW_MAX];
  swm_tap_t ctap    [WINDOW_MAX];
  logic     rb      [WINDOW_MAX+1];

  assign rb[0] = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_tap_t up_tap;
    swm_tap_t lo_ctap;

    if (i == WINDOW_MAX - 1) begin : g_top
      assign up_tap = '0;
    end else begin : g_mid
      assign up_tap = own_tap[i+1];
    end

    if (i == 0) begin : g_bot
      assign lo_ctap = '0;
    end else begin : g_upr
      assign lo_ctap = ctap[i-1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .load       (accept),
      .sample     (sample),
      .oldest_age (oldest_age),
      .remove     (remove),
      .occupied   (CNT_W'(i) < fill_base),
      .kept       (CNT_W'(i) < kept_cnt),
      .rb_in      (rb[i]),
      .rb_out     (rb[i+1]),
      .up_tap     (up_tap),
      .own_tap    (own_tap[i]),
      .lo_ctap    (lo_ctap),
      .ctap       (ctap[i])
    );
  end

  // Middle positions: equal for an odd window, adjacent for an even one.
  logic [IDX_W-1:0] mid_lo;
  logic [IDX_W-1:0] mid_hi;

  assign mid_lo = IDX_W'((win_size - CNT_W'(1)) >> 1);
  assign mid_hi = IDX_W'(win_size >> 1);

  // Result stage 1: pick the candidate within each group of cells.
  logic signed [SMP_W-1:0] grp_val [GRP_CNT][GRP_SIZE];
  logic signed [SMP_W-1:0] lo_cand [GRP_CNT];
  logic signed [SMP_W-1:0] hi_cand [GRP_CNT];

  for (genvar g = 0; g < GRP_CNT; g++) begin : g_grp
    for (genvar e = 0; e < GRP_SIZE; e++) begin : g_elem
      assign grp_val[g][e] = own_tap[g*GRP_SIZE + e].val;
    end
  end

  // Stage handshakes: each stage moves when the one after it has room.
  logic out_adv;
  logic s1_adv;

  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = !s1_valid || out_adv;
  assign in_stall = pend && !s1_adv;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int g = 0; g < GRP_CNT; g++) begin
        lo_cand[g] <= grp_val[g][mid_lo[SUB_W-1:0]];
        hi_cand[g] <= grp_val[g][mid_hi[SUB_W-1:0]];
      end
    end
  end

  // Result stage 2: pick the group and form the doubled median.
  logic signed [SMP_W-1:0] lo_sel;
  logic signed [SMP_W-1:0] hi_sel;
  logic signed [MED_W-1:0] med_sum;

  assign lo_sel  = lo_cand[mid_lo[IDX_W-1:SUB_W]];
  assign hi_sel  = hi_cand[mid_hi[IDX_W-1:SUB_W]];
  assign med_sum = MED_W'(lo_sel) + MED_W'(hi_sel);

  always_ff @(posedge clk) begin
    if (out_adv) begin
      median_doubled <= med_sum;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      win_size  <= CNT_W'(1);
      fill      <= '0;
      pend      <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        win_size <= eff_size(cfg_data);
        fill     <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (s1_adv) begin
        pend     <= accept && emit;
        s1_valid <= pend;
      end else if (!pend) begin
        // stage 1 blocked but the row is free: a beat taken now still owes
        pend <= accept && emit;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule
`default_nettype wire

/* design/swm_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module swm_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire signed [swm_pkg::MED_W-1:0] median_doubled
);

  `SWM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(median_doubled), "stalled result changed")

  `SWM_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid && !in_stall, "reset left handshake active")

  // Input only backs up once the output side is blocked.
  `SWM_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output stall")

  // Each new result comes from an accepted sample that moved through pend, s1_valid and out_valid in turn.
  `SWM_ASSERT(a_rise_src, $rose(out_valid) |-> $past(in_valid && !in_stall, 3), "result without sample")

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .median_doubled (median_doubled)
);
`default_nettype wire
